### rtl/mbld_pkg.sv
// Shared types, mode codes and character classification for the mail body line decoder.
package mbld_pkg;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_B64  = 2'd1;
  localparam logic [1:0] MODE_QP   = 2'd2;

  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_EQ  = 8'd61;
  localparam logic [7:0] CHAR_PLS = 8'd43;
  localparam logic [7:0] CHAR_SLS = 8'd47;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_SIGN = 2'd1;
  localparam logic [1:0] ESC_HELD = 2'd2;

  localparam int MaxRes = 3;

  // Up to three decoded bytes handed to the result buffer, byte 0 goes out first.
  typedef struct packed {
    logic                          valid;
    logic [1:0]                    cnt;
    logic [MaxRes-1:0][7:0]        bytes;
  } res_t;

  // {hit, 6-bit value} of a base64 alphabet character.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'd65:8'd90]}) begin
      d = c - 8'd65;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'd97:8'd122]}) begin
      d = c - 8'd71;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'd48:8'd57]}) begin
      d = c + 8'd4;
      return {1'b1, d[5:0]};
    end else if (c == CHAR_PLS) begin
      return {1'b1, 6'd62};
    end else if (c == CHAR_SLS) begin
      return {1'b1, 6'd63};
    end
    return {1'b0, d[5:0]};
  endfunction

  // {hit, 4-bit value} of a hex digit, either case.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'd48:8'd57]}) begin
      d = c - 8'd48;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'd65:8'd70]}) begin
      d = c - 8'd55;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'd97:8'd102]}) begin
      d = c - 8'd87;
      return {1'b1, d[3:0]};
    end
    return {1'b0, d[3:0]};
  endfunction

endpackage

### rtl/mail_body_line_decoder_top.sv
// Top level of the mail body line decoder: mode register, decode core and result buffer.
//
// Input channel (in_valid/in_ready): one word per cycle, a character in
// in_char_in or a line end when in_line_end is set. Output channel
// (out_valid/out_ready): decoded bytes, out_last set on the final byte a
// word causes. Config channel (cfg_valid/cfg_ready) writes the decode mode:
// 0 passthrough, 1 base64, 2 quoted-printable; always ready. The user must
// see that it is written only while the block is idle; the block itself
// does not enforce this. The first byte of a word passes through the input
// register and then the result buffer before it shows on out_*. One word
// per cycle is taken while each word yields at most one byte and the
// receiver is ready; a word with two or three bytes (line end with a pending
// escape, escape whose first character is not a hex digit) holds the result
// buffer until it has drained, one byte per cycle while the receiver is
// ready. Words that yield nothing retire without touching the buffer. Reset
// clears the mode to passthrough and all line state. On a receiver stall the
// buffer keeps its bytes and in_ready drops when a word with bytes is waiting.
module mail_body_line_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_decode_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic       out_last
);
  import mbld_pkg::*;

  logic [1:0] mode_r;
  res_t       res;
  logic       can_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_decode_mode;
    end
  end

  mbld_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode        (mode_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char_in  (in_char_in),
    .in_line_end (in_line_end),
    .can_load    (can_load),
    .res_o       (res)
  );

  mbld_obuf u_obuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_i        (res),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte_out (out_byte_out),
    .out_last     (out_last)
  );

  // a load always carries at least one byte
  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (res.cnt != 2'd0))
    else $error("empty load into result buffer");

  // never overwrite bytes that are still owed to the receiver
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> can_load)
    else $error("result buffer overwritten");

  // a load shows up on the output in the next cycle with its first byte
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (out_valid && (out_byte_out == $past(res.bytes[0]))))
    else $error("loaded byte not presented");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

### rtl/mbld_core.sv
// Input register, line state and single-pass decode of one word into up to three bytes.
module mbld_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_in,
  input  logic              in_line_end,
  input  logic              can_load,
  output mbld_pkg::res_t    res_o
);
  import mbld_pkg::*;

  logic        v_r, v_nxt;
  logic [7:0]  char_r;
  logic        end_r;

  logic [11:0] acc_r, acc_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        pad_r, pad_nxt;
  logic [1:0]  esc_r, esc_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [1:0]            cnt;
  logic [MaxRes-1:0][7:0] bytes;
  logic [6:0]            sx;
  logic [4:0]            hi, lo;
  logic [11:0]           acc_sh;
  logic                  move;

  always_comb begin
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    cnt       = 2'd0;
    bytes     = '0;
    sx        = sextet_of(char_r);
    hi        = hex_of(held_r);
    lo        = hex_of(char_r);
    acc_sh    = {acc_r[5:0], sx[5:0]};

    if (end_r) begin
      // flush an unfinished escape literally, then the newline
      case (esc_r)
        ESC_IDLE: begin
          bytes[0] = CHAR_LF;
          cnt      = 2'd1;
        end
        ESC_SIGN: begin
          bytes[0] = CHAR_EQ;
          bytes[1] = CHAR_LF;
          cnt      = 2'd2;
        end
        default: begin
          bytes[0] = CHAR_EQ;
          bytes[1] = held_r;
          bytes[2] = CHAR_LF;
          cnt      = 2'd3;
        end
      endcase
      acc_nxt   = '0;
      phase_nxt = '0;
      pad_nxt   = 1'b0;
      esc_nxt   = ESC_IDLE;
      held_nxt  = '0;
    end else begin
      case (mode)
        MODE_B64: begin
          if (!pad_r) begin
            if (char_r == CHAR_EQ) begin
              pad_nxt = 1'b1;
            end else if (sx[6]) begin
              acc_nxt   = acc_sh;
              phase_nxt = phase_r + 2'd1;
              case (phase_r)
                2'd1: begin
                  bytes[0] = acc_sh[11:4];
                  cnt      = 2'd1;
                end
                2'd2: begin
                  bytes[0] = acc_sh[9:2];
                  cnt      = 2'd1;
                end
                2'd3: begin
                  bytes[0] = acc_sh[7:0];
                  cnt      = 2'd1;
                end
                default: cnt = 2'd0;
              endcase
            end
          end
        end
        MODE_QP: begin
          case (esc_r)
            ESC_IDLE: begin
              if (char_r == CHAR_EQ) begin
                esc_nxt = ESC_SIGN;
              end else begin
                bytes[0] = char_r;
                cnt      = 2'd1;
              end
            end
            ESC_SIGN: begin
              held_nxt = char_r;
              esc_nxt  = ESC_HELD;
            end
            default: begin
              if (!hi[4]) begin
                bytes[0] = CHAR_EQ;
                bytes[1] = held_r;
                bytes[2] = char_r;
                cnt      = 2'd3;
              end else if (!lo[4]) begin
                bytes[0] = {4'h0, hi[3:0]};
                cnt      = 2'd1;
              end else begin
                bytes[0] = {hi[3:0], lo[3:0]};
                cnt      = 2'd1;
              end
              esc_nxt  = ESC_IDLE;
              held_nxt = '0;
            end
          endcase
        end
        default: begin
          bytes[0] = char_r;
          cnt      = 2'd1;
        end
      endcase
    end
  end

  // a word that yields nothing retires even while the buffer is busy
  assign move     = v_r && ((cnt == 2'd0) || can_load);
  assign in_ready = !v_r || move;

  assign res_o.valid = move && (cnt != 2'd0);
  assign res_o.cnt   = cnt;
  assign res_o.bytes = bytes;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (move) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      acc_r   <= '0;
      phase_r <= '0;
      pad_r   <= 1'b0;
      esc_r   <= ESC_IDLE;
      held_r  <= '0;
    end else begin
      v_r <= v_nxt;
      if (move) begin
        acc_r   <= acc_nxt;
        phase_r <= phase_nxt;
        pad_r   <= pad_nxt;
        esc_r   <= esc_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_in;
      end_r  <= in_line_end;
    end
  end

endmodule

### rtl/mbld_obuf.sv
// Result buffer: sends a word's decoded bytes one per cycle while out_ready.
module mbld_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  mbld_pkg::res_t    res_i,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte_out,
  output logic              out_last
);
  import mbld_pkg::*;

  logic [MaxRes-1:0][7:0] bytes_r, bytes_nxt;
  logic [1:0]             rem_r, rem_nxt;

  assign out_valid    = (rem_r != 2'd0);
  assign out_byte_out = bytes_r[0];
  assign out_last     = (rem_r == 2'd1);
  assign can_load     = (rem_r == 2'd0) || (out_last && out_ready);

  always_comb begin
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    if (res_i.valid) begin
      rem_nxt   = res_i.cnt;
      bytes_nxt = res_i.bytes;
    end else if (out_valid && out_ready) begin
      rem_nxt   = rem_r - 2'd1;
      bytes_nxt = {8'h00, bytes_r[MaxRes-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule
